// File: rtl/turing_machine_step_defines.svh
// ----------------------------------------------------------------------------
// Turing machine step engine: assertion macros
// Shared assertion shorthands for the RTL of the step engine.
// ----------------------------------------------------------------------------
`ifndef TURING_MACHINE_STEP_DEFINES_SVH
`define TURING_MACHINE_STEP_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define TMS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) \
    (ante) |-> (cons)) else $error("same-cycle check failed");

// next-cycle implication, checked on every rising edge out of reset
`define TMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) \
    (ante) |=> (cons)) else $error("next-cycle check failed");

`endif

// File: rtl/tms_pkg.sv
// ----------------------------------------------------------------------------
// Turing machine step engine: package
// Sizes, field widths and codes shared by the engine and its memories.
// ----------------------------------------------------------------------------
package tms_pkg;

  // machine sizes
  localparam int unsigned TAPE_CELLS = 1024;
  localparam int unsigned SYMBOLS    = 16;
  localparam int unsigned STATES     = 16;

  // field widths
  localparam int unsigned HEAD_W  = $clog2(TAPE_CELLS);
  localparam int unsigned SYM_W   = $clog2(SYMBOLS);
  localparam int unsigned STATE_W = $clog2(STATES);
  localparam int unsigned MOVE_W  = 2;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned RULE_W  = SYM_W + MOVE_W + STATE_W;
  localparam int unsigned RULE_DEPTH = STATES * SYMBOLS;
  localparam int unsigned CFG_W   = (HEAD_W > STATE_W) ? HEAD_W : STATE_W;
  localparam int unsigned CFG_IDX_W = 1;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD    = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE   = 3'd1;
  localparam logic [OP_W-1:0] OP_READ    = 3'd2;
  localparam logic [OP_W-1:0] OP_RESTART = 3'd3;
  localparam logic [OP_W-1:0] OP_STEP    = 3'd4;

  // head move codes
  localparam logic [MOVE_W-1:0] MOVE_LEFT  = 2'd0;
  localparam logic [MOVE_W-1:0] MOVE_STAY  = 2'd1;
  localparam logic [MOVE_W-1:0] MOVE_RIGHT = 2'd2;

  // result kinds
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD  = 1'b1;

  // reset values
  localparam logic [STATE_W-1:0] RESET_STATE = STATE_W'(1);
  localparam logic [HEAD_W-1:0]  RESET_HEAD  = HEAD_W'(501);

endpackage

// File: rtl/tms_ram.sv
// ----------------------------------------------------------------------------
// Turing machine step engine: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tms_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/turing_machine_step.sv
// ----------------------------------------------------------------------------
// Turing machine step engine: top level
// Tape and rule table in synchronous RAMs, sequenced by a small controller.
// ----------------------------------------------------------------------------
// channel   | ports                                      | handshake
// ----------+--------------------------------------------+------------------------
// request   | operation_i .. next_state_i                | start high, busy low
// result    | kind_o .. fault_o                          | result_valid_o, 1 cycle
// config    | cfg_we_i, cfg_index_i, cfg_wdata_i         | write when cfg_we_i high
//
// a step runs a tape read, then a rule lookup keyed by the symbol read,
// then tape write-back and head/state update (the last two skipped while halted).
// read cell answers after the tape read; load rule, write cell and restart act on acceptance.
// after reset the tape is cleared one cell a cycle, busy high.
// the result receiver cannot stall; a result shows for exactly one cycle.
// ----------------------------------------------------------------------------
`include "turing_machine_step_defines.svh"

module turing_machine_step (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [tms_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tms_pkg::CFG_W-1:0]      cfg_wdata_i,
  // requests
  input  logic                           start,
  output logic                           busy,
  input  logic [tms_pkg::OP_W-1:0]       operation_i,
  input  logic [tms_pkg::HEAD_W-1:0]     cell_address_i,
  input  logic [tms_pkg::STATE_W-1:0]    state_index_i,
  input  logic [tms_pkg::SYM_W-1:0]      symbol_index_i,
  input  logic [tms_pkg::SYM_W-1:0]      new_symbol_i,
  input  logic [tms_pkg::MOVE_W-1:0]     move_i,
  input  logic [tms_pkg::STATE_W-1:0]    next_state_i,
  // results
  output logic                           result_valid_o,
  output logic                           kind_o,
  output logic [tms_pkg::SYM_W-1:0]      symbol_o,
  output logic [tms_pkg::STATE_W-1:0]    machine_state_o,
  output logic [tms_pkg::HEAD_W-1:0]     head_position_o,
  output logic                           halted_o,
  output logic                           fault_o
);

  import tms_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_TAPE,
    S_RULE
  } state_e;

  state_e               state_q, state_d;
  logic [HEAD_W-1:0]    clr_q, clr_d;
  logic                 is_read_q, is_read_d;
  logic [STATE_W-1:0]   cur_q, cur_d;
  logic [HEAD_W-1:0]    head_q, head_d;
  logic                 fault_q, fault_d;
  logic [STATE_W-1:0]   start_state_q, start_state_d;
  logic [HEAD_W-1:0]    start_head_q, start_head_d;

  logic                 res_valid_q, res_valid_d;
  logic                 res_kind_q, res_kind_d;
  logic [SYM_W-1:0]     res_sym_q, res_sym_d;
  logic [STATE_W-1:0]   res_state_q, res_state_d;
  logic [HEAD_W-1:0]    res_head_q, res_head_d;
  logic                 res_fault_q, res_fault_d;

  logic                 accept;
  logic                 tape_we;
  logic [HEAD_W-1:0]    tape_waddr;
  logic [SYM_W-1:0]     tape_wdata;
  logic [HEAD_W-1:0]    tape_raddr;
  logic [SYM_W-1:0]     tape_rdata;
  logic                 rule_we;
  logic [RULE_W-1:0]    rule_rdata;
  logic [SYM_W-1:0]     rule_sym;
  logic [MOVE_W-1:0]    rule_mv;
  logic [STATE_W-1:0]   rule_nst;

  // request handshake
  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // rule word fields
  assign rule_sym = rule_rdata[RULE_W-1 -: SYM_W];
  assign rule_mv  = rule_rdata[STATE_W +: MOVE_W];
  assign rule_nst = rule_rdata[STATE_W-1:0];

  // tape write port: clearing sweep, write cell, or step write-back
  always_comb begin
    tape_we    = 1'b0;
    tape_waddr = cell_address_i;
    tape_wdata = symbol_index_i;
    case (state_q)
      S_CLEAR: begin
        tape_we    = 1'b1;
        tape_waddr = clr_q;
        tape_wdata = '0;
      end
      S_IDLE: begin
        tape_we = accept && (operation_i == OP_WRITE);
      end
      S_RULE: begin
        tape_we    = 1'b1;
        tape_waddr = head_q;
        tape_wdata = rule_sym;
      end
      default: begin
        tape_we = 1'b0;
      end
    endcase
  end

  assign tape_raddr = (operation_i == OP_READ) ? cell_address_i : head_q;
  assign rule_we    = accept && (operation_i == OP_LOAD);

  // tape memory
  tms_ram #(
    .DEPTH (TAPE_CELLS),
    .WIDTH (SYM_W)
  ) u_tape (
    .clk_i   (clk_i),
    .we_i    (tape_we),
    .waddr_i (tape_waddr),
    .wdata_i (tape_wdata),
    .raddr_i (tape_raddr),
    .rdata_o (tape_rdata)
  );

  // rule table keyed by {state, symbol read}
  tms_ram #(
    .DEPTH (RULE_DEPTH),
    .WIDTH (RULE_W)
  ) u_rule (
    .clk_i   (clk_i),
    .we_i    (rule_we),
    .waddr_i ({state_index_i, symbol_index_i}),
    .wdata_i ({new_symbol_i, move_i, next_state_i}),
    .raddr_i ({cur_q, tape_rdata}),
    .rdata_o (rule_rdata)
  );

  // controller next state
  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    is_read_d     = is_read_q;
    cur_d         = cur_q;
    head_d        = head_q;
    fault_d       = fault_q;
    start_state_d = start_state_q;
    start_head_d  = start_head_q;
    res_valid_d   = 1'b0;
    res_kind_d    = res_kind_q;
    res_sym_d     = res_sym_q;
    res_state_d   = res_state_q;
    res_head_d    = res_head_q;
    res_fault_d   = res_fault_q;

    // configuration writes
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_START_STATE: start_state_d = cfg_wdata_i[STATE_W-1:0];
        CFG_START_HEAD:  start_head_d  = cfg_wdata_i[HEAD_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + HEAD_W'(1);
        if (clr_q == HEAD_W'(TAPE_CELLS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (operation_i)
            OP_READ: begin
              is_read_d = 1'b1;
              state_d   = S_TAPE;
            end
            OP_STEP: begin
              is_read_d = 1'b0;
              state_d   = S_TAPE;
            end
            OP_RESTART: begin
              cur_d   = start_state_q;
              head_d  = start_head_q;
              fault_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_TAPE: begin
        // read cell answer or report of a step while halted
        if (is_read_q || (cur_q == '0) || fault_q) begin
          res_valid_d = 1'b1;
          res_kind_d  = is_read_q ? KIND_READ : KIND_STEP;
          res_sym_d   = tape_rdata;
          res_state_d = cur_q;
          res_head_d  = head_q;
          res_fault_d = fault_q;
          state_d     = S_IDLE;
        end else begin
          state_d = S_RULE;
        end
      end
      S_RULE: begin
        // apply the rule of the symbol read
        case (rule_mv)
          MOVE_LEFT: begin
            if (head_q == '0) fault_d = 1'b1;
            else              head_d  = head_q - HEAD_W'(1);
          end
          MOVE_RIGHT: begin
            if (head_q == HEAD_W'(TAPE_CELLS - 1)) fault_d = 1'b1;
            else                                  head_d  = head_q + HEAD_W'(1);
          end
          default: ;
        endcase
        cur_d       = rule_nst;
        res_valid_d = 1'b1;
        res_kind_d  = KIND_STEP;
        res_sym_d   = rule_sym;
        res_state_d = rule_nst;
        res_head_d  = head_d;
        res_fault_d = fault_d;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      clr_q         <= '0;
      is_read_q     <= 1'b0;
      cur_q         <= RESET_STATE;
      head_q        <= RESET_HEAD;
      fault_q       <= 1'b0;
      start_state_q <= RESET_STATE;
      start_head_q  <= RESET_HEAD;
      res_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      clr_q         <= clr_d;
      is_read_q     <= is_read_d;
      cur_q         <= cur_d;
      head_q        <= head_d;
      fault_q       <= fault_d;
      start_state_q <= start_state_d;
      start_head_q  <= start_head_d;
      res_valid_q   <= res_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    res_kind_q  <= res_kind_d;
    res_sym_q   <= res_sym_d;
    res_state_q <= res_state_d;
    res_head_q  <= res_head_d;
    res_fault_q <= res_fault_d;
  end

  assign result_valid_o  = res_valid_q;
  assign kind_o          = res_kind_q;
  assign symbol_o        = res_sym_q;
  assign machine_state_o = res_state_q;
  assign head_position_o = res_head_q;
  assign halted_o        = (res_state_q == '0) || res_fault_q;
  assign fault_o         = res_fault_q;

  // checks
  `TMS_ASSERT_NEXT(a_single_strobe, clk_i, rst_ni, result_valid_o, !result_valid_o)
  `TMS_ASSERT_NEXT(a_step_holds_busy, clk_i, rst_ni,
                   accept && (operation_i == OP_STEP), busy && !result_valid_o)
  `TMS_ASSERT_NEXT(a_fault_sticky, clk_i, rst_ni,
                   fault_q && !(accept && (operation_i == OP_RESTART)), fault_q)
  `TMS_ASSERT_IMPLIES(a_no_result_in_clear, clk_i, rst_ni,
                      state_q == S_CLEAR, !result_valid_o && !rule_we)

endmodule
